>>> rtl/core/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types and constants for the Huffman tree bit decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int CLEN_W = 6;
  localparam int BYTE_W = 8;

  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_DECODE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DEC
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SYM_W-1:0]  code_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [CLEN_W-1:0] code_length;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             walk_error;
    logic             last_of_byte;
  } out_item_t;

  // One decode event from the walker to the output stage
  typedef struct packed {
    logic             res;     // a new result this cycle
    logic [SYM_W-1:0] symbol;
    logic             err;
    logic             close;   // the current byte ends this cycle
  } walk_ev_t;

endpackage

>>> rtl/core/huffman_tree_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_top
// Huffman decoder over a node table with code loading and bitwise walk.
// ----------------------------------------------------------------------------
// Operation: the block works on one item at a time. A clear is done at
// accept. A load runs through accept, one node step per code bit (with
// code_length capped at MAX_CODE_LEN) and the final symbol write; a load
// that runs out of table space ends early. A decode byte runs through
// accept, eight bit steps and a closing leaf check, plus an extra step for
// each symbol whose leaf is directly followed by a missing child at the
// root, and it waits while the output side stalls. A saved walk position is
// fetched during accept, so it costs no extra step. Each bit step that
// descends is one dependent read of the node memory, whose registered read
// data paces the walk; the root node lives in a register so no step waits for it.
module huffman_tree_bit_decoder_top import htbd_pkg::*; #(
  parameter int NODE_COUNT   = NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int WORD_W = 2 * IDX_W + SYM_W;
  localparam int RGT_LSB = SYM_W;
  localparam int LFT_LSB = SYM_W + IDX_W;
  localparam logic [3:0] BIT_FIN = 4'(BYTE_W);

  state_e state_q, state_d;

  logic [WORD_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  nodes_q, nodes_d;
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  logic              cache_ok_q, cache_ok_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic              fresh_q, fresh_d;
  logic              base_rd_q, base_rd_d;
  logic              arr_q, arr_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [BYTE_W-1:0] byte_q, byte_d;

  logic              in_acc;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, rd_word;
  walk_ev_t          ev;
  logic              em_ok;

  // load path
  logic [WORD_W-1:0] ld_w;
  logic [6:0]        ld_pos;
  logic              ld_bit;
  logic [IDX_W-1:0]  ld_child;
  logic              ld_done, ld_has, tbl_full;
  logic [IDX_W-1:0]  new_idx;
  logic [6:0]        clen_ext, clen_sat;

  // decode path
  logic              dec_fin, leaf, derr, emit_req, dec_go;
  logic [WORD_W-1:0] dbase;
  logic [IDX_W-1:0]  dchild;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ld_w     = fresh_q ? '0 : (base_rd_q ? rd_word : root_q);
  assign ld_pos   = 7'(len_q) - 7'd1;
  assign ld_bit   = (ld_pos < 7'd32) ? code_q[ld_pos[4:0]] : 1'b0;
  assign ld_child = ld_bit ? ld_w[RGT_LSB +: IDX_W] : ld_w[LFT_LSB +: IDX_W];
  assign ld_done  = (len_q == '0);
  assign ld_has   = (ld_child != '0);
  assign tbl_full = (nodes_q == CNT_W'(NODE_COUNT));
  assign new_idx  = nodes_q[IDX_W-1:0];
  assign clen_ext = 7'(in_data_i.code_length);
  assign clen_sat = (clen_ext > 7'(MAX_CODE_LEN)) ? 7'(MAX_CODE_LEN) : clen_ext;

  assign dec_fin  = (cnt_q == BIT_FIN);
  assign leaf     = arr_q && (rd_word[LFT_LSB +: IDX_W] == '0);
  assign dbase    = (leaf || !base_rd_q) ? root_q : rd_word;
  assign dchild   = byte_q[BYTE_W-1] ? dbase[RGT_LSB +: IDX_W] : dbase[LFT_LSB +: IDX_W];
  assign derr     = (dchild == '0);
  assign emit_req = leaf || (!dec_fin && derr);
  assign dec_go   = !emit_req || em_ok;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.req_type)
            REQ_LOAD:   state_d = ST_LOAD;
            REQ_DECODE: state_d = ST_DEC;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (ld_done || (!ld_has && tbl_full)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DEC: begin
        if (dec_fin && dec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    root_d     = root_q;
    nodes_d    = nodes_q;
    cursor_d   = cursor_q;
    cache_ok_d = cache_ok_q;
    cur_d      = cur_q;
    fresh_d    = fresh_q;
    base_rd_d  = base_rd_q;
    arr_d      = arr_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    code_d     = code_q;
    sym_d      = sym_q;
    byte_d     = byte_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_q;
    ram_wdata  = ld_w;
    ram_re     = 1'b0;
    ram_raddr  = dchild;
    ev         = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.req_type)
            REQ_CLEAR: begin
              root_d     = '0;
              nodes_d    = CNT_W'(1);
              cursor_d   = '0;
              cache_ok_d = 1'b0;
            end
            REQ_LOAD: begin
              cur_d      = '0;
              fresh_d    = 1'b0;
              base_rd_d  = 1'b0;
              len_d      = LEN_W'(clen_sat);
              code_d     = in_data_i.code_bits;
              sym_d      = in_data_i.code_symbol;
              cache_ok_d = 1'b0;
            end
            REQ_DECODE: begin
              byte_d = in_data_i.data_byte;
              cnt_d  = '0;
              arr_d  = 1'b0;
              cur_d  = cursor_q;
              if (cursor_q == '0) begin
                base_rd_d = 1'b0;
              end else begin
                base_rd_d = 1'b1;
                // refetch the saved position unless its word is still held
                if (!cache_ok_q) begin
                  ram_re    = 1'b1;
                  ram_raddr = cursor_q;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_LOAD: begin
        if (ld_done) begin
          ram_we    = 1'b1;
          ram_wdata = {ld_w[LFT_LSB +: IDX_W], ld_w[RGT_LSB +: IDX_W], sym_q};
        end else if (ld_has) begin
          ram_re    = 1'b1;
          ram_raddr = ld_child;
          cur_d     = ld_child;
          base_rd_d = 1'b1;
          len_d     = len_q - LEN_W'(1);
        end else if (tbl_full) begin
          // drop the rest; a node allocated by this load still gets its zeros
          ram_we    = fresh_q;
          ram_wdata = '0;
        end else begin
          ram_we = 1'b1;
          if (ld_bit) begin
            ram_wdata = {ld_w[LFT_LSB +: IDX_W], new_idx, ld_w[SYM_W-1:0]};
          end else begin
            ram_wdata = {new_idx, ld_w[RGT_LSB +: IDX_W], ld_w[SYM_W-1:0]};
          end
          cur_d   = new_idx;
          fresh_d = 1'b1;
          nodes_d = nodes_q + CNT_W'(1);
          len_d   = len_q - LEN_W'(1);
        end
      end

      ST_DEC: begin
        if (dec_go) begin
          if (dec_fin) begin
            ev.res     = leaf;
            ev.symbol  = rd_word[SYM_W-1:0];
            ev.err     = 1'b0;
            ev.close   = 1'b1;
            cursor_d   = leaf ? '0 : cur_q;
            cache_ok_d = arr_q && !leaf;
          end else if (leaf && derr) begin
            // emit the leaf now, then take the same bit again from the root
            ev.res    = 1'b1;
            ev.symbol = rd_word[SYM_W-1:0];
            arr_d     = 1'b0;
            base_rd_d = 1'b0;
            cur_d     = '0;
          end else begin
            if (leaf) begin
              ev.res    = 1'b1;
              ev.symbol = rd_word[SYM_W-1:0];
            end else if (derr) begin
              ev.res = 1'b1;
              ev.err = 1'b1;
            end
            if (derr) begin
              arr_d     = 1'b0;
              base_rd_d = 1'b0;
              cur_d     = '0;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = dchild;
              arr_d     = 1'b1;
              base_rd_d = 1'b1;
              cur_d     = dchild;
            end
            byte_d = {byte_q[BYTE_W-2:0], 1'b0};
            cnt_d  = cnt_q + 4'd1;
          end
        end
      end

      default: ;
    endcase

    // keep the root copy in step with the table
    if (ram_we && (ram_waddr == '0)) begin
      root_d = ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      root_q     <= '0;
      nodes_q    <= CNT_W'(1);
      cursor_q   <= '0;
      cache_ok_q <= 1'b0;
      cur_q      <= '0;
      fresh_q    <= 1'b0;
      base_rd_q  <= 1'b0;
      arr_q      <= 1'b0;
      cnt_q      <= '0;
      len_q      <= '0;
    end else begin
      state_q    <= state_d;
      root_q     <= root_d;
      nodes_q    <= nodes_d;
      cursor_q   <= cursor_d;
      cache_ok_q <= cache_ok_d;
      cur_q      <= cur_d;
      fresh_q    <= fresh_d;
      base_rd_q  <= base_rd_d;
      arr_q      <= arr_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    sym_q  <= sym_d;
    byte_q <= byte_d;
  end

  htbd_node_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (WORD_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_word)
  );

  htbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .em_ok_o     (em_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/htbd_node_ram.sv
// ----------------------------------------------------------------------------
// htbd_node_ram
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module htbd_node_ram import htbd_pkg::*; #(
  parameter int DEPTH  = NODE_COUNT_DEF,
  parameter int ADDR_W = $clog2(NODE_COUNT_DEF),
  parameter int DATA_W = 2 * $clog2(NODE_COUNT_DEF) + SYM_W
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/htbd_out_stage.sv
// ----------------------------------------------------------------------------
// htbd_out_stage
// Result staging: holds the newest result until its last-of-byte flag is
// known, then moves it to the output register.
// ----------------------------------------------------------------------------
module htbd_out_stage import htbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  walk_ev_t  ev_i,
  output logic      em_ok_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic             pend_v_q, pend_v_d;
  logic             pend_fin_q, pend_fin_d;
  logic [SYM_W-1:0] pend_sym_q, pend_sym_d;
  logic             pend_err_q, pend_err_d;
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;

  logic out_free;
  logic last_now;
  logic move;

  assign out_free = !out_v_q || !out_stall_i;
  assign last_now = pend_fin_q || (ev_i.close && !ev_i.res);
  assign move     = pend_v_q && out_free && (ev_i.res || last_now);
  assign em_ok_o  = !pend_v_q || out_free;

  always_comb begin
    pend_v_d   = pend_v_q;
    pend_fin_d = pend_fin_q;
    pend_sym_d = pend_sym_q;
    pend_err_d = pend_err_q;
    out_v_d    = out_v_q;
    out_d      = out_q;

    if (move) begin
      out_d.out_symbol   = pend_sym_q;
      out_d.walk_error   = pend_err_q;
      out_d.last_of_byte = last_now;
      out_v_d            = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    if (ev_i.res) begin
      pend_v_d   = 1'b1;
      pend_fin_d = ev_i.close;
      pend_sym_d = ev_i.symbol;
      pend_err_d = ev_i.err;
    end else if (move) begin
      pend_v_d = 1'b0;
    end else if (ev_i.close && pend_v_q) begin
      pend_fin_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q   <= 1'b0;
      pend_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      pend_v_q   <= pend_v_d;
      pend_fin_q <= pend_fin_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    pend_err_q <= pend_err_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/sv/htbd_monitor.sv
// ----------------------------------------------------------------------------
// htbd_monitor
// Watches both channels of the Huffman tree bit decoder. Keeps its own copy
// of the node table and walk position, works out the symbols each accepted
// beat should produce, and compares every output beat field by field.
// ----------------------------------------------------------------------------
module htbd_monitor import htbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_W = $clog2(NODE_COUNT_DEF);

  logic [NODE_W-1:0] tree_left  [NODE_COUNT_DEF];
  logic [NODE_W-1:0] tree_right [NODE_COUNT_DEF];
  logic [SYM_W-1:0]  tree_sym   [NODE_COUNT_DEF];
  logic [NODE_W:0]   tree_nodes;
  logic [NODE_W-1:0] walk_pos;
  out_item_t         symbols_due [$];
  int                fails;

  function automatic void insert_code(input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] bits,
                                      input logic [CLEN_W-1:0] len);
    int                depth;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] nxt;
    depth = (len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : int'(len);
    node  = '0;
    for (int k = depth; k > 0; k--) begin
      nxt = bits[k-1] ? tree_right[node] : tree_left[node];
      if (nxt == '0) begin
        // table full: drop the rest of this code, keep what was allocated
        if (tree_nodes >= NODE_COUNT_DEF) return;
        nxt = tree_nodes[NODE_W-1:0];
        tree_nodes++;
        tree_left[nxt]  = '0;
        tree_right[nxt] = '0;
        tree_sym[nxt]   = '0;
        if (bits[k-1]) tree_right[node] = nxt;
        else tree_left[node] = nxt;
      end
      node = nxt;
    end
    tree_sym[node] = sym;
  endfunction

  function automatic void predict_symbols(input logic [BYTE_W-1:0] data);
    logic [NODE_W-1:0] pos;
    logic [NODE_W-1:0] nxt;
    out_item_t         res;
    logic              have_res;
    pos      = walk_pos;
    res      = '0;
    have_res = 1'b0;
    for (int j = BYTE_W - 1; j >= 0; j--) begin
      nxt = data[j] ? tree_right[pos] : tree_left[pos];
      // a missing child or a node without a left child ends the walk
      if (nxt == '0 || tree_left[nxt] == '0) begin
        if (have_res) symbols_due.push_back(res);
        res.walk_error   = (nxt == '0);
        res.out_symbol   = (nxt == '0) ? '0 : tree_sym[nxt];
        res.last_of_byte = 1'b0;
        have_res = 1'b1;
        pos = '0;
      end else begin
        pos = nxt;
      end
    end
    walk_pos = pos;
    if (have_res) begin
      res.last_of_byte = 1'b1;
      symbols_due.push_back(res);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NODE_COUNT_DEF; i++) begin
        tree_left[i]  = '0;
        tree_right[i] = '0;
        tree_sym[i]   = '0;
      end
      tree_nodes = (NODE_W+1)'(1);
      walk_pos   = '0;
      symbols_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.req_type)
          REQ_CLEAR: begin
            tree_left[0]  = '0;
            tree_right[0] = '0;
            tree_sym[0]   = '0;
            tree_nodes    = (NODE_W+1)'(1);
            walk_pos      = '0;
          end
          REQ_LOAD: begin
            insert_code(in_data_i.code_symbol, in_data_i.code_bits, in_data_i.code_length);
          end
          REQ_DECODE: begin
            predict_symbols(in_data_i.data_byte);
          end
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (symbols_due.size() == 0) begin
          $error("unexpected result beat: out_symbol %0h walk_error %0b last_of_byte %0b",
                 out_data_i.out_symbol, out_data_i.walk_error, out_data_i.last_of_byte);
          fails++;
        end else begin
          want = symbols_due.pop_front();
          if (out_data_i.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %0h, got %0h", want.out_symbol, out_data_i.out_symbol);
            fails++;
          end
          if (out_data_i.walk_error !== want.walk_error) begin
            $error("walk_error: expected %0b, got %0b", want.walk_error, out_data_i.walk_error);
            fails++;
          end
          if (out_data_i.last_of_byte !== want.last_of_byte) begin
            $error("last_of_byte: expected %0b, got %0b",
                   want.last_of_byte, out_data_i.last_of_byte);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= symbols_due.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Huffman tree bit decoder. Runs a short
// directed pass over the corner cases, then random prefix codes loaded and
// decoded, noise beats and table-full loads, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htbd_pkg::*;

  localparam int IDLE_PCT    = 17;
  localparam int ITEM_TARGET = 200;
  // generous next to a full-length load or a decode under stall
  localparam int IDLE_LIMIT  = 5000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  logic      quiet     = 1'b0;
  int        items_sent = 0;
  int        idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  huffman_tree_bit_decoder_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  htbd_monitor u_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t noise_item();
    in_item_t item;
    item.req_type    = 2'($urandom_range(0, 3));
    item.code_symbol = 8'($urandom);
    item.code_bits   = $urandom;
    item.code_length = 6'($urandom_range(0, 63));
    item.data_byte   = 8'($urandom);
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.req_type inside {REQ_CLEAR, REQ_LOAD, REQ_DECODE}) items_sent++;
  endtask

  task automatic send_clear();
    in_item_t item;
    item = noise_item();
    item.req_type = REQ_CLEAR;
    send_item(item);
  endtask

  task automatic send_load(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] bits,
                           input logic [CLEN_W-1:0] len);
    in_item_t item;
    item = noise_item();
    item.req_type    = REQ_LOAD;
    item.code_symbol = sym;
    item.code_bits   = bits;
    item.code_length = len;
    send_item(item);
  endtask

  task automatic send_decode(input logic [BYTE_W-1:0] data);
    in_item_t item;
    item = noise_item();
    item.req_type  = REQ_DECODE;
    item.data_byte = data;
    send_item(item);
  endtask

  // drop valid and hold until every predicted symbol has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int                seq;
    int                pick;
    logic [CODE_W-1:0] leaf_bits [$];
    logic [CLEN_W-1:0] leaf_len  [$];
    logic [CODE_W-1:0] b;
    logic [CLEN_W-1:0] l;
    in_item_t          odd;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty tree: every bit is a missing child
    send_decode(8'h00);
    // empty code lands on the root, which never decodes
    send_load(8'hA5, '0, '0);
    send_decode(8'hFF);
    // complete code: 0, 10, 11
    send_load(8'h00, 32'd0, 6'd1);
    send_load(8'hFF, 32'd2, 6'd2);
    send_load(8'h3C, 32'd3, 6'd2);
    send_decode(8'h00);
    send_decode(8'hFF);
    // walk position carries over into the next byte
    send_decode(8'h01);
    send_decode(8'h80);
    send_decode(8'h01);
    // load while the walk is parked mid-code
    send_load(8'h5A, 32'd3, 6'd3);
    send_decode(8'h40);
    odd = '1;
    send_item(odd);
    // over-long codes saturate to the maximum length
    send_load(8'hC3, '1, 6'd63);
    send_load(8'h81, 32'h8000_0001, 6'd32);
    send_load(8'h7E, $urandom, 6'd40);
    send_decode(8'hFF);
    send_clear();
    send_decode(8'hAA);
    // lone code 00: a 1 after the first 0 has no child
    send_load(8'h11, 32'd0, 6'd2);
    send_decode(8'h40);
    send_decode(8'h55);
    send_clear();
    wait_drained();

    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet <= (seq >= 5 && seq < 9);
      if (seq == 3 || seq == 11) begin
        // fill the node table with long random codes until loads get dropped
        send_clear();
        repeat (22) send_load(8'($urandom), $urandom, 6'($urandom_range(32, 63)));
        repeat (4) send_decode(8'($urandom));
      end else if ($urandom_range(0, 99) < 75) begin
        // grow a random prefix code by splitting leaves
        leaf_bits.delete();
        leaf_len.delete();
        leaf_bits.push_back('0);
        leaf_len.push_back('0);
        repeat ($urandom_range(0, 23)) begin
          pick = $urandom_range(0, leaf_bits.size() - 1);
          if (leaf_len[pick] < 12) begin
            b = leaf_bits[pick] << 1;
            l = leaf_len[pick] + 6'd1;
            leaf_bits[pick] = b;
            leaf_len[pick]  = l;
            leaf_bits.push_back(b | 32'd1);
            leaf_len.push_back(l);
          end
        end
        // leave a hole now and then so some walks run off the tree
        if (leaf_bits.size() > 1 && $urandom_range(0, 3) == 0) begin
          pick = $urandom_range(0, leaf_bits.size() - 1);
          leaf_bits.delete(pick);
          leaf_len.delete(pick);
        end
        send_clear();
        while (leaf_bits.size() > 0) begin
          pick = $urandom_range(0, leaf_bits.size() - 1);
          send_load(8'($urandom), leaf_bits[pick], leaf_len[pick]);
          leaf_bits.delete(pick);
          leaf_len.delete(pick);
          if ($urandom_range(0, 9) == 0) send_decode(8'($urandom));
        end
        repeat ($urandom_range(3, 10)) send_decode(8'($urandom));
      end else begin
        repeat (8) send_item(noise_item());
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
      seq++;
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
